[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[hdl/iwbc_pkg.sv]
// ----------------------------------------------------------------------------
// iwbc_pkg
// Types and constants of the issue window barrier check block.
// ----------------------------------------------------------------------------
package iwbc_pkg;

	localparam int BUFFER_DEPTH = 64;
	localparam int SLOT_W       = $clog2(BUFFER_DEPTH);
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int NUM_W        = 32;
	localparam int WLIM_W       = 7;
	localparam int ILIM_W       = 5;
	localparam int SLOTS_W      = 5;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 7;

	typedef enum logic [2:0] {
		K_INSERT   = 3'd0,
		K_QUERY    = 3'd1,
		K_ISSUE    = 3'd2,
		K_COMPLETE = 3'd3,
		K_TICK     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_OVER_WIDTH = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LIMIT = 1'b0,
		REG_ISSUE_LIMIT  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_QSCAN,
		S_TSCAN,
		S_DELIVER
	} state_t;

	localparam logic [SLOTS_W-1:0] SLOTS_MAX = '1;

endpackage

[hdl/issue_window_barrier_check.sv]
// ----------------------------------------------------------------------------
// issue_window_barrier_check
// Instruction window and reorder tracker with barrier issue checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one event per transaction:
//   insert, query, issue, complete or tick. Output channel (out_valid /
//   out_stall) returns exactly one result transaction per event.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
//   writes window_limit (index 0) and issue_limit (index 1); cfg_ready is
//   always high, write only while the block is idle.
//   Steps: insert, issue, complete, unused kinds and a query that fails its
//   width or window check go from acceptance straight to the delivery state,
//   then to the output register. Any other query first scans the held entries
//   from the oldest until one fails or the scan passes the newest; a tick
//   first retires the oldest entries while they are done or exit-marked.
//   The scan steps through the mark registers one entry a cycle through one
//   shared compare unit. One event is in flight at a time; in_stall is high
//   while it is at work, so the next event is taken no earlier than the edge
//   at which the result leaves. The output register holds a result while
//   out_stall is high; the next event is accepted meanwhile and waits for
//   the output register. Reset clears marks, limits, head and next numbers.
// ----------------------------------------------------------------------------
module issue_window_barrier_check
	import iwbc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            kind,
	input  logic [NUM_W-1:0]      seq_number,
	input  logic                  barrier_flag,
	input  logic                  phi_flag,
	input  logic                  exit_only,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [NUM_W-1:0]      assigned_number,
	output logic                  issue_ok,
	output logic [1:0]            status,
	output logic [CNT_W-1:0]      retired_count,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t                  state_q, state_d;
	logic [BUFFER_DEPTH-1:0] done_q, exit_q, bar_q;
	logic [NUM_W-1:0]        head_q, next_q, wf_q, wl_q;
	logic [SLOTS_W-1:0]      slots_q;
	logic [WLIM_W-1:0]       win_limit_q;
	logic [ILIM_W-1:0]       iss_limit_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    stop2_q;
	logic                    out_valid_q;

	logic [NUM_W-1:0]        pos_q;
	logic                    isbar_q;
	logic [NUM_W-1:0]        res_assigned_q;
	logic                    res_ok_q;
	status_t                 res_status_q;
	logic [CNT_W-1:0]        res_retired_q;
	logic [NUM_W-1:0]        out_assigned_q;
	logic                    out_ok_q;
	logic [1:0]              out_status_q;
	logic [CNT_W-1:0]        out_retired_q;

	logic                    in_acc, out_free;
	logic [CNT_W-1:0]        held;
	logic                    full, over_width, pre_fail;
	logic [NUM_W-1:0]        scan_n;
	logic [SLOT_W-1:0]       scan_s, head_s, next_s, seq_s;
	logic                    scan_lt, scan_gt, stop2_now, q_fail, q_end, t_go;
	logic                    cmp_held;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign held       = CNT_W'(next_q - head_q);
	assign full       = (held >= CNT_W'(BUFFER_DEPTH));
	assign over_width = (iss_limit_q != '0) && (slots_q >= iss_limit_q);
	assign pre_fail   = over_width ||
		((win_limit_q != '0) && ((seq_number < wf_q) || (seq_number > wl_q)));
	assign cmp_held   = ((seq_number - head_q) < {{(NUM_W-CNT_W){1'b0}}, held});

	assign head_s = head_q[SLOT_W-1:0];
	assign next_s = next_q[SLOT_W-1:0];
	assign seq_s  = seq_number[SLOT_W-1:0];

	assign scan_n    = head_q + {{(NUM_W-CNT_W){1'b0}}, idx_q};
	assign scan_s    = scan_n[SLOT_W-1:0];
	assign scan_lt   = (scan_n < pos_q);
	assign scan_gt   = (win_limit_q != '0) && (scan_n > wl_q);
	assign stop2_now = stop2_q || scan_gt;
	assign q_fail    = (bar_q[scan_s] && scan_lt) ||
		(isbar_q && !stop2_now && scan_lt && !done_q[scan_s]);
	assign q_end     = (idx_q == held);
	assign t_go      = (held != '0) && (done_q[head_s] || exit_q[head_s]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (kind_t'(kind))
						K_QUERY: state_d = pre_fail ? S_DELIVER : S_QSCAN;
						K_TICK:  state_d = S_TSCAN;
						default: state_d = S_DELIVER;
					endcase
				end
			end
			S_QSCAN: begin
				if (q_end || q_fail) begin
					state_d = S_DELIVER;
				end
			end
			S_TSCAN: begin
				if (!t_go) begin
					state_d = S_DELIVER;
				end
			end
			S_DELIVER: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			exit_q      <= '0;
			bar_q       <= '0;
			head_q      <= '0;
			next_q      <= '0;
			wf_q        <= '0;
			wl_q        <= '1;
			slots_q     <= '0;
			win_limit_q <= '0;
			iss_limit_q <= '0;
			idx_q       <= '0;
			stop2_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_IDLE && in_acc) begin
				idx_q   <= '0;
				stop2_q <= 1'b0;
				case (kind_t'(kind))
					K_INSERT: begin
						if (!full) begin
							done_q[next_s] <= 1'b0;
							exit_q[next_s] <= 1'b0;
							bar_q[next_s]  <= barrier_flag;
							next_q         <= next_q + 1'b1;
						end
					end
					K_ISSUE: begin
						if (!over_width && !phi_flag && slots_q < SLOTS_MAX) begin
							slots_q <= slots_q + 1'b1;
						end
					end
					K_COMPLETE: begin
						if (cmp_held) begin
							if (exit_only) begin
								exit_q[seq_s] <= 1'b1;
							end else begin
								done_q[seq_s] <= 1'b1;
							end
						end
					end
					K_TICK: begin
						slots_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == S_QSCAN) begin
				idx_q   <= idx_q + 1'b1;
				stop2_q <= stop2_now;
			end
			if (state_q == S_TSCAN && t_go) begin
				done_q[head_s] <= 1'b0;
				exit_q[head_s] <= 1'b0;
				bar_q[head_s]  <= 1'b0;
				head_q         <= head_q + 1'b1;
				wf_q           <= head_q + 1'b1;
				wl_q           <= head_q + {{(NUM_W-WLIM_W){1'b0}}, win_limit_q};
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_WINDOW_LIMIT: begin
						win_limit_q <= cfg_data[WLIM_W-1:0];
						wl_q <= wf_q + {{(NUM_W-WLIM_W){1'b0}}, cfg_data[WLIM_W-1:0]} - 1'b1;
					end
					REG_ISSUE_LIMIT: begin
						iss_limit_q <= cfg_data[ILIM_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (state_q == S_DELIVER && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			pos_q          <= seq_number;
			isbar_q        <= barrier_flag;
			res_assigned_q <= '0;
			res_ok_q       <= 1'b0;
			res_status_q   <= ST_OK;
			res_retired_q  <= '0;
			case (kind_t'(kind))
				K_INSERT: begin
					if (full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_assigned_q <= next_q;
					end
				end
				K_ISSUE: begin
					if (over_width) begin
						res_status_q <= ST_OVER_WIDTH;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_QSCAN && q_end) begin
			res_ok_q <= 1'b1;
		end
		if (state_q == S_TSCAN && t_go) begin
			res_retired_q <= res_retired_q + 1'b1;
		end
		if (state_q == S_DELIVER && out_free) begin
			out_assigned_q <= res_assigned_q;
			out_ok_q       <= res_ok_q;
			out_status_q   <= res_status_q;
			out_retired_q  <= res_retired_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign assigned_number = out_assigned_q;
	assign issue_ok        = out_ok_q;
	assign status          = out_status_q;
	assign retired_count   = out_retired_q;

`include "assert_macros.svh"

	`ASSERT_NEVER(a_held_in_range, held > CNT_W'(BUFFER_DEPTH), "held entries exceed depth")
	`ASSERT_PROP(a_window_consistent,
		wl_q == wf_q + {{(NUM_W-WLIM_W){1'b0}}, win_limit_q} - 1'b1,
		"window bounds out of step with limit")
	`ASSERT_NEVER(a_scan_bound, state_q == S_QSCAN && idx_q > held, "query scan past held entries")
	`ASSERT_PROP(a_result_source, $rose(out_valid_q) |-> $past(state_q == S_DELIVER),
		"result shown without delivery step")
	`ASSERT_NEVER(a_tick_overrun, state_q == S_TSCAN && t_go && head_q == next_q,
		"retire past newest entry")

endmodule
